FILE: sv/mtt_pkg.sv
// Shared types and constants for the markup tag tokenizer.
`default_nettype none
package mtt_pkg;

  // Markup characters
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Parser phase
  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_NAME = 2'd1,
    PH_ATTR = 2'd2
  } phase_t;

  // Byte classification
  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_ATTR   = 2'd2,
    KIND_MARKUP = 2'd3
  } kind_t;

  // Events raised on a word
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_TEXT     = 2'd1,
    EV_TAG      = 2'd2,
    EV_TAG_ATTR = 2'd3
  } event_t;

  // One result word
  typedef struct packed {
    logic [7:0] byte_val;
    kind_t      kind;
    event_t     ev;
    logic       sup;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/markup_tag_tokenizer_unit.sv
// Markup tag tokenizer: classifies document bytes and raises text and tag events.
// Result words are registered: into the result register, or into skid on a stall.
// Throughput: one byte per cycle while in_stall is low (skid register empty).
// A two-entry output buffer (result register plus skid register) lets input
// continue while a result waits; input stalls only when the skid entry is full.
// Reset (rst, synchronous) empties the output buffer and returns the parser to text.
`default_nettype none
module markup_tag_tokenizer_unit import mtt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       start_of_doc,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      byte_kind,
  output logic [1:0]      event_res,
  output logic            suppressed
);

  // Parser state
  phase_t     phase, phase_next;
  logic       in_quotes, in_quotes_next;
  logic       comment_candidate, comment_candidate_next;
  logic [1:0] name_char_count, name_char_count_next;
  logic       in_comment, in_comment_next;
  logic [1:0] dash_run, dash_run_next;
  logic       text_nonempty, text_nonempty_next;

  // Output buffer
  result_t result, skid, res_now;
  logic    result_valid, skid_valid;

  logic accept;
  logic out_free;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !result_valid || !out_stall;

  // Work out the result and next state for the incoming word
  always_comb begin
    phase_t     ph;
    logic       quo;
    logic       cand;
    logic [1:0] cnt;
    logic       cmt;
    logic [1:0] dash;
    logic       txt;
    logic       spc;
    logic [7:0] want;
    kind_t      kind;
    event_t     ev;

    // Start of document clears all state before the byte is handled
    if (start_of_doc) begin
      ph   = PH_TEXT;
      quo  = 1'b0;
      cand = 1'b1;
      cnt  = 2'd0;
      cmt  = 1'b0;
      dash = 2'd0;
      txt  = 1'b0;
    end else begin
      ph   = phase;
      quo  = in_quotes;
      cand = comment_candidate;
      cnt  = name_char_count;
      cmt  = in_comment;
      dash = dash_run;
      txt  = text_nonempty;
    end

    spc  = (in_byte == CH_SP) || (in_byte == CH_TAB) || (in_byte == CH_NL);
    want = (cnt == 2'd0) ? CH_BANG : CH_DASH;
    kind = KIND_MARKUP;
    ev   = EV_NONE;

    unique case (ph)
      PH_NAME: begin
        if (in_byte == CH_GT) begin
          ev = EV_TAG;
          ph = PH_TEXT;
        end else if (spc) begin
          ph = PH_ATTR;
        end else begin
          kind = KIND_NAME;
          // Track the comment-open prefix
          if (cand && cnt != 2'd3) begin
            if (in_byte != want) begin
              cand = 1'b0;
            end else if (cnt == 2'd2) begin
              cmt = 1'b1;
            end
            cnt = cnt + 2'd1;
          end
        end
      end
      PH_ATTR: begin
        if (quo || in_byte != CH_GT) begin
          kind = KIND_ATTR;
          if (in_byte == CH_QUOTE) begin
            quo = !quo;
          end
        end else begin
          ev = EV_TAG_ATTR;
          ph = PH_TEXT;
        end
      end
      default: begin
        // Text, and the unused phase code behaves as text
        if (in_byte == CH_LT) begin
          if (txt) begin
            ev = EV_TEXT;
          end
          txt  = 1'b0;
          ph   = PH_NAME;
          cand = 1'b1;
          cnt  = 2'd0;
        end else begin
          kind = KIND_TEXT;
          txt  = 1'b1;
        end
      end
    endcase

    res_now.byte_val = in_byte;
    res_now.kind     = kind;
    res_now.ev       = ev;
    res_now.sup      = cmt;

    // Close a comment on '>' after two dashes, after the event is decided
    priority if (in_byte == CH_DASH) begin
      if (dash != 2'd2) begin
        dash = dash + 2'd1;
      end
    end else if (in_byte == CH_GT && dash == 2'd2) begin
      dash = 2'd0;
      cmt  = 1'b0;
    end else begin
      dash = 2'd0;
    end

    phase_next             = ph;
    in_quotes_next         = quo;
    comment_candidate_next = cand;
    name_char_count_next   = cnt;
    in_comment_next        = cmt;
    dash_run_next          = dash;
    text_nonempty_next     = txt;
  end

  // Advance parser state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TEXT;
      in_quotes         <= 1'b0;
      comment_candidate <= 1'b1;
      name_char_count   <= 2'd0;
      in_comment        <= 1'b0;
      dash_run          <= 2'd0;
      text_nonempty     <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      in_quotes         <= in_quotes_next;
      comment_candidate <= comment_candidate_next;
      name_char_count   <= name_char_count_next;
      in_comment        <= in_comment_next;
      dash_run          <= dash_run_next;
      text_nonempty     <= text_nonempty_next;
    end
  end

  // Output buffer control: hold in skid while the result register is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      result_valid <= skid_valid || accept;
      skid_valid   <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      result <= skid_valid ? skid : res_now;
    end else if (accept) begin
      skid <= res_now;
    end
  end

  assign out_valid  = result_valid;
  assign out_byte   = result.byte_val;
  assign byte_kind  = result.kind;
  assign event_res  = result.ev;
  assign suppressed = result.sup;

endmodule
`default_nettype wire
